FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked every edge outside reset.
`define SAC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Checked every edge, reset included.
`define SAC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");
`endif

FILE: rtl/sac_pkg.sv
// Shared types and constants of the cache tag model.
`default_nettype none
package sac_pkg;
  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_W      = 32;
  localparam int WORD_BYTES  = 4;
  localparam int AGE_W       = 32;
  localparam int TIME_W      = 64;
  localparam int ELAPSED_W   = 16;
  localparam int COST_W      = 24;

  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x / 2;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int OFF_BITS    = flog2(BLOCK_BYTES);
  localparam int SET_BITS    = flog2(SETS);
  localparam int SET_W       = (SET_BITS == 0) ? 1 : SET_BITS;
  localparam int TAG_W       = ADDR_W - OFF_BITS - SET_BITS;
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CHUNK_WORDS = BLOCK_BYTES / WORD_BYTES;

  // configuration register indexes
  localparam logic [1:0] REG_HIT_CYCLES  = 2'd0;
  localparam logic [1:0] REG_LOWER_CYCLES = 2'd1;
  localparam logic [1:0] REG_MEM_CYCLES  = 2'd2;

  typedef struct packed {
    logic [7:0]  hit_cycles;
    logic [11:0] lower_cycles;
    logic [9:0]  mem_cycles;
  } cfg_t;

  typedef struct packed {
    logic              wr;
    logic [SET_W-1:0]  set;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              dirty;
    logic [TIME_W-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic              wr;
    logic              hit;
    logic [COST_W-1:0] cost;
  } res_t;
endpackage
`default_nettype wire

FILE: rtl/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sac_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(D > 1 ? D : 2)-1:0] waddr,
  input  wire logic [W-1:0]                 wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(D > 1 ? D : 2)-1:0] raddr,
  output logic      [W-1:0]                 rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sac_front.sv
// Front end: takes words, splits the address, stamps time, queues requests.
`default_nettype none
module sac_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [sac_pkg::ADDR_W-1:0]    in_address,
  input  wire logic [sac_pkg::ELAPSED_W-1:0] in_elapsed,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output sac_pkg::req_t                      q_req
);
  import sac_pkg::*;

  logic [TIME_W-1:0] time_r, time_nxt;
  req_t              ent_r [2];
  logic              rd_ptr_r, wr_ptr_r;
  logic [1:0]        cnt_r;
  logic              push;
  req_t              new_req;
  logic [ADDR_W-1:0] blk;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = ent_r[rd_ptr_r];
  assign time_nxt = time_r + TIME_W'(in_elapsed);
  assign blk      = in_address >> OFF_BITS;

  always_comb begin
    new_req.wr    = in_opcode;
    new_req.set   = (SET_BITS == 0) ? '0 : SET_W'(blk);
    new_req.tag   = TAG_W'(blk >> SET_BITS);
    new_req.stamp = time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r   <= '0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        time_r          <= time_nxt;
        ent_r[wr_ptr_r] <= new_req;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sac_back.sv
// Back end: reads the set, ages ways, picks hit or victim, writes back, reports.
`default_nettype none
module sac_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sac_pkg::cfg_t              cfg,
  input  wire logic                       q_valid,
  output logic                            q_pop,
  input  wire sac_pkg::req_t              q_req,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output sac_pkg::res_t                   res
);
  import sac_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_SEL} state_t;

  state_t           state_r;
  req_t             req_r;
  logic [WAYS-1:0]  vld_r [SETS];
  logic [WAYS-1:0]  set_vld_r;
  logic             hit_r;
  logic [WAY_W-1:0] hit_way_r;
  logic [AGE_W-1:0] age_r [WAYS];
  logic             res_valid_r;
  res_t             res_r;

  logic [$bits(row_t)-1:0] rdata;
  row_t             row, wrow;
  logic             ram_we;
  logic [TIME_W-1:0] diff [WAYS];
  logic             hit_c;
  logic [WAY_W-1:0] hit_way_c;
  logic [WAY_W-1:0] vic;
  logic             found;
  logic [WAY_W-1:0] upd_way;
  logic [COST_W-1:0] chunk, cost;
  logic             can_out;

  assign row     = row_t'(rdata);
  assign can_out = !res_valid_r || res_ready;
  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign ram_we  = (state_r == S_SEL) && can_out;

  sac_ram #(.W($bits(row_t)), .D(SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (($clog2(SETS > 1 ? SETS : 2))'(req_r.set)),
    .wdata (wrow),
    .re    (q_pop),
    .raddr (($clog2(SETS > 1 ? SETS : 2))'(q_req.set)),
    .rdata (rdata)
  );

  // tag match and age of every way
  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    for (int i = 0; i < WAYS; i++) begin
      diff[i] = req_r.stamp - row[i].stamp;
      if (!hit_c && vld_r[req_r.set][i] && row[i].tag == req_r.tag) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(i);
      end
    end
  end

  // victim: first free way, else oldest with lowest index on ties
  always_comb begin
    vic   = '0;
    found = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found) begin
        if (!set_vld_r[i]) begin
          vic   = WAY_W'(i);
          found = 1'b1;
        end else if (age_r[i] > age_r[vic]) begin
          vic = WAY_W'(i);
        end
      end
    end
  end

  always_comb begin
    chunk   = COST_W'(cfg.mem_cycles) * COST_W'(CHUNK_WORDS);
    cost    = COST_W'(cfg.hit_cycles);
    upd_way = hit_r ? hit_way_r : vic;
    wrow    = row;
    if (hit_r) begin
      wrow[upd_way].dirty = row[upd_way].dirty | req_r.wr;
    end else begin
      cost = cost + COST_W'(cfg.lower_cycles) + chunk;
      if (!found && row[vic].dirty) begin
        cost = cost + chunk;
      end
      wrow[upd_way].tag   = req_r.tag;
      wrow[upd_way].dirty = req_r.wr;
      wrow[upd_way].stamp = req_r.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      for (int s = 0; s < SETS; s++) begin
        vld_r[s] <= '0;
      end
    end else begin
      if (res_valid_r && res_ready && !ram_we) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r   <= q_req;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          hit_r     <= hit_c;
          hit_way_r <= hit_way_c;
          set_vld_r <= vld_r[req_r.set];
          for (int i = 0; i < WAYS; i++) begin
            age_r[i] <= (|diff[i][TIME_W-1:AGE_W]) ? '1 : diff[i][AGE_W-1:0];
          end
          state_r <= S_SEL;
        end
        S_SEL: begin
          if (can_out) begin
            vld_r[req_r.set][upd_way] <= 1'b1;
            res_valid_r <= 1'b1;
            res_r.wr    <= req_r.wr;
            res_r.hit   <= hit_r;
            res_r.cost  <= cost;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_tag_model_unit.sv
// Top level of the set-associative write-back cache tag and timing model.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/ready   | opcode, address, elapsed
//  out_    | output    | out_valid/ready  | is_load .. store_miss, cost_cycles
//  cfg_    | input     | cfg_we           | cfg_idx, cfg_wdata
//
// In the back end each word goes through set read from the tag RAM,
// age and tag compare, then victim pick with write-back of the set row.
// The front end queues up to two words, so input keeps flowing during lookups.
// Ages come from a 64-bit instruction clock stamped at fill; no sweep needed.
// Reset (synchronous, rst_n low) clears valid bits, queue and the clock.
// A stalled result holds the back end in its last step; the queue absorbs input.
`default_nettype none
module set_assoc_cache_tag_model_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [sac_pkg::ADDR_W-1:0]    in_address,
  input  wire logic [sac_pkg::ELAPSED_W-1:0] in_elapsed,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_is_load,
  output logic                               out_is_store,
  output logic                               out_load_hit,
  output logic                               out_load_miss,
  output logic                               out_store_hit,
  output logic                               out_store_miss,
  output logic [sac_pkg::COST_W-1:0]         out_cost_cycles,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_idx,
  input  wire logic [11:0]                   cfg_wdata
);
  import sac_pkg::*;

  cfg_t cfg_r;
  logic q_valid, q_pop;
  req_t q_req;
  res_t res;

  // config registers, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_cycles   <= 8'd1;
      cfg_r.lower_cycles <= 12'd0;
      cfg_r.mem_cycles   <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HIT_CYCLES:   cfg_r.hit_cycles   <= cfg_wdata[7:0];
        REG_LOWER_CYCLES: cfg_r.lower_cycles <= cfg_wdata;
        REG_MEM_CYCLES:   cfg_r.mem_cycles   <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  sac_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_address (in_address),
    .in_elapsed (in_elapsed),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_req      (q_req)
  );

  sac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_is_load     = !res.wr;
  assign out_is_store    = res.wr;
  assign out_load_hit    = !res.wr && res.hit;
  assign out_load_miss   = !res.wr && !res.hit;
  assign out_store_hit   = res.wr && res.hit;
  assign out_store_miss  = res.wr && !res.hit;
  assign out_cost_cycles = res.cost;
endmodule
`default_nettype wire

FILE: rtl/sac_check.sv
// Port-level checks of the cache tag model, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sac_check (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_opcode,
  input wire logic [sac_pkg::ADDR_W-1:0]    in_address,
  input wire logic [sac_pkg::ELAPSED_W-1:0] in_elapsed,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_is_load,
  input wire logic                          out_is_store,
  input wire logic                          out_load_hit,
  input wire logic                          out_load_miss,
  input wire logic                          out_store_hit,
  input wire logic                          out_store_miss,
  input wire logic [sac_pkg::COST_W-1:0]    out_cost_cycles
);
  `SAC_ASSERT(a_one_outcome, clk, rst_n, out_valid |-> $onehot({out_load_hit, out_load_miss, out_store_hit, out_store_miss}))
  `SAC_ASSERT(a_kind_match, clk, rst_n, out_valid |-> (out_is_load == (out_load_hit || out_load_miss)) && (out_is_store != out_is_load))
  `SAC_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_cost_cycles))
  `SAC_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable({in_opcode, in_address, in_elapsed}))
  `SAC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
endmodule

bind set_assoc_cache_tag_model_unit sac_check u_sac_check (.*);
`default_nettype wire

FILE: dv/set_assoc_cache_tag_model_unit_tb.sv
// Self-checking testbench for the cache tag and timing model.
`default_nettype none
module set_assoc_cache_tag_model_unit_tb;
  import sac_pkg::*;

  localparam int LINES = SETS * WAYS;
  localparam logic [31:0] AGE_SAT = 32'hFFFF_FFFF;

  // One access word as the sender sees it.
  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
    logic [15:0] elapsed;
  } access_t;

  // One result word as the receiver sees it.
  typedef struct packed {
    logic        is_load;
    logic        is_store;
    logic        load_hit;
    logic        load_miss;
    logic        store_hit;
    logic        store_miss;
    logic [23:0] cost;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_opcode;
  logic [31:0] in_address;
  logic [15:0] in_elapsed;
  logic out_valid;
  logic out_ready;
  logic out_is_load;
  logic out_is_store;
  logic out_load_hit;
  logic out_load_miss;
  logic out_store_hit;
  logic out_store_miss;
  logic [23:0] out_cost_cycles;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [11:0] cfg_wdata;

  set_assoc_cache_tag_model_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_address(in_address), .in_elapsed(in_elapsed),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_load(out_is_load), .out_is_store(out_is_store),
    .out_load_hit(out_load_hit), .out_load_miss(out_load_miss),
    .out_store_hit(out_store_hit), .out_store_miss(out_store_miss),
    .out_cost_cycles(out_cost_cycles),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the tag store and registers.
  logic [31:0] shadow_tag[LINES];
  logic        shadow_valid[LINES];
  logic        shadow_dirty[LINES];
  logic [31:0] shadow_age[LINES];
  logic [7:0]  lookup_cycles;
  logic [11:0] lower_cycles;
  logic [9:0]  mem_word_cycles;

  access_t  pending_words[$];   // waiting for the driver
  outcome_t expected_outcomes[$];
  int errors = 0;
  int n_hits = 0;
  int n_misses = 0;
  int n_checked = 0;
  int send_idle_pct = 0;        // percent of cycles the sender holds off
  int recv_idle_pct = 0;        // percent of cycles the receiver stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runs one access against the shadow state and returns what the block
  // should report. Every valid way ages first, whole cache, saturating.
  function automatic outcome_t cache_access(access_t a);
    outcome_t o;
    logic [SET_W-1:0] set_sel;
    logic [31:0] tag_val;
    int base;
    int victim;
    logic hit;
    logic free_way;
    logic [31:0] chunk;
    logic [31:0] cost;
    logic [32:0] sum;
    set_sel = a.address[OFF_BITS +: SET_BITS];
    tag_val = a.address >> (OFF_BITS + SET_BITS);
    base = int'(set_sel) * WAYS;
    chunk = CHUNK_WORDS * mem_word_cycles;
    cost = 32'(lookup_cycles);
    hit = 1'b0;
    free_way = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      if (shadow_valid[i]) begin
        sum = {1'b0, shadow_age[i]} + 33'(a.elapsed);
        shadow_age[i] = sum[32] ? AGE_SAT : sum[31:0];
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && shadow_valid[base + w] && shadow_tag[base + w] == tag_val) begin
        hit = 1'b1;
        if (a.opcode) shadow_dirty[base + w] = 1'b1;
      end
    end
    if (!hit) begin
      victim = base;
      cost = cost + 32'(lower_cycles) + chunk;
      for (int w = 0; w < WAYS; w++) begin
        if (!free_way) begin
          if (!shadow_valid[base + w]) begin
            victim = base + w;
            free_way = 1'b1;
          end else if (shadow_age[base + w] > shadow_age[victim]) begin
            victim = base + w;
          end
        end
      end
      // write-back charged only for a dirty line actually evicted
      if (!free_way && shadow_dirty[victim]) cost = cost + chunk;
      shadow_tag[victim] = tag_val;
      shadow_valid[victim] = 1'b1;
      shadow_dirty[victim] = a.opcode;
      shadow_age[victim] = '0;
    end
    o.is_load = !a.opcode;
    o.is_store = a.opcode;
    o.load_hit = !a.opcode && hit;
    o.load_miss = !a.opcode && !hit;
    o.store_hit = a.opcode && hit;
    o.store_miss = a.opcode && !hit;
    o.cost = cost[23:0];
    return o;
  endfunction

  // Driver: valid holds until accepted; the next word can go out in the same
  // step the previous one is taken, so valid is assigned once per step.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          expected_outcomes.push_back(cache_access({in_opcode, in_address, in_elapsed}));
        end
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          access_t a;
          a = pending_words.pop_front();
          in_valid <= 1'b1;
          in_opcode <= a.opcode;
          in_address <= a.address;
          in_elapsed <= a.elapsed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        outcome_t got;
        outcome_t exp_o;
        got = {out_is_load, out_is_store, out_load_hit, out_load_miss,
               out_store_hit, out_store_miss, out_cost_cycles};
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: %h", $time, got);
        end else begin
          exp_o = expected_outcomes.pop_front();
          n_checked++;
          if (exp_o.load_hit || exp_o.store_hit) n_hits++; else n_misses++;
          if (got.is_load !== exp_o.is_load || got.is_store !== exp_o.is_store) begin
            errors++;
            $display("%0t: kind mismatch exp ld/st %b%b got %b%b", $time,
                     exp_o.is_load, exp_o.is_store, got.is_load, got.is_store);
          end
          if (got.load_hit !== exp_o.load_hit || got.load_miss !== exp_o.load_miss ||
              got.store_hit !== exp_o.store_hit || got.store_miss !== exp_o.store_miss) begin
            errors++;
            $display("%0t: hit/miss mismatch exp %b%b%b%b got %b%b%b%b", $time,
                     exp_o.load_hit, exp_o.load_miss, exp_o.store_hit, exp_o.store_miss,
                     got.load_hit, got.load_miss, got.store_hit, got.store_miss);
          end
          if (got.cost !== exp_o.cost) begin
            errors++;
            $display("%0t: cost mismatch exp %0d got %0d", $time, exp_o.cost, got.cost);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HIT_CYCLES:   lookup_cycles = val[7:0];
      REG_LOWER_CYCLES: lower_cycles = val;
      REG_MEM_CYCLES:   mem_word_cycles = val[9:0];
      default: ;
    endcase
  endtask

  // Waits for all queued words to be taken and all results checked, plus a
  // margin for the back-end pipeline.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] make_addr(int set_sel, logic [31:0] tag_val,
                                            logic [5:0] off);
    return (tag_val << (OFF_BITS + SET_BITS)) | (set_sel << OFF_BITS) | off;
  endfunction

  // Random phase: mostly accesses clustered on a few sets and a small tag pool
  // so hits, full sets, FIFO eviction and dirty write-backs all occur.
  task automatic queue_random(int count);
    access_t a;
    int s;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      a.opcode = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: a.address = $urandom();
        1: begin
          s = $urandom_range(SETS - 1);
          t = $urandom();
          a.address = make_addr(s, t, 6'($urandom()));
        end
        default: begin
          s = $urandom_range(3);
          t = $urandom_range(7);
          if ($urandom_range(1)) t = t | 32'h03FF_FFF8;
          a.address = make_addr(s, t, 6'($urandom()));
        end
      endcase
      case ($urandom_range(7))
        0: a.elapsed = 16'hFFFF;
        1: a.elapsed = 16'h0;
        2: a.elapsed = 16'($urandom());
        default: a.elapsed = 16'($urandom_range(20));
      endcase
      pending_words.push_back(a);
    end
  endtask

  initial begin
    access_t a;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_HIT_CYCLES;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_address = '0;
    in_elapsed = '0;
    out_ready = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_age[i] = '0;
    end
    lookup_cycles = 8'd1;
    lower_cycles = 12'd0;
    mem_word_cycles = 10'd100;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset register values, address extremes, fill set 0 past
    // its ways so a dirty line gets evicted, read and write hits.
    pending_words.push_back('{1'b0, 32'h0000_0000, 16'h0000});
    pending_words.push_back('{1'b1, 32'hFFFF_FFFF, 16'hFFFF});
    pending_words.push_back('{1'b1, 32'h0000_0000, 16'h0001});
    pending_words.push_back('{1'b0, 32'hFFFF_FFC0, 16'h0000});
    for (int w = 1; w <= WAYS; w++)
      pending_words.push_back('{1'b1, make_addr(0, w, 6'h3F), 16'h0002});
    pending_words.push_back('{1'b0, make_addr(0, 32'h0, 6'h0), 16'h0});
    pending_words.push_back('{1'b0, make_addr(0, 32'h2, 6'h0), 16'h0});
    pending_words.push_back('{1'b1, 32'hAAAA_AAAA, 16'h5555});
    pending_words.push_back('{1'b0, 32'h5555_5555, 16'hAAAA});
    drain();

    // Register extremes, plus an unused index that must be ignored. Large ages:
    // a stretch of max elapsed values on set 5, short of age saturation.
    write_reg(REG_HIT_CYCLES, 12'd255);
    write_reg(REG_LOWER_CYCLES, 12'd4095);
    write_reg(REG_MEM_CYCLES, 12'd1023);
    write_reg(2'd3, 12'hFFF);
    for (int i = 0; i < 6; i++)
      pending_words.push_back('{1'b1, make_addr(5, i, 6'h0), 16'hFFFF});
    for (int i = 0; i < 6; i++)
      pending_words.push_back('{1'b0, make_addr(5, i + 2, 6'h0), 16'hFFFF});
    drain();

    write_reg(REG_HIT_CYCLES, 12'd0);
    write_reg(REG_LOWER_CYCLES, 12'd0);
    write_reg(REG_MEM_CYCLES, 12'd0);
    send_idle_pct = 26;
    recv_idle_pct = 79;
    queue_random(300);
    drain();

    write_reg(REG_HIT_CYCLES, 12'($urandom_range(1, 255)));
    write_reg(REG_LOWER_CYCLES, 12'($urandom_range(4095)));
    write_reg(REG_MEM_CYCLES, 12'($urandom_range(1023)));
    send_idle_pct = 79;
    recv_idle_pct = 26;
    queue_random(300);
    drain();

    write_reg(REG_HIT_CYCLES, 12'd1);
    write_reg(REG_LOWER_CYCLES, 12'd37);
    write_reg(REG_MEM_CYCLES, 12'd100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(325);
    drain();

    $display("checked %0d results: %0d hits, %0d misses", n_checked, n_hits, n_misses);
    if (errors == 0) begin
      $display("set_assoc_cache_tag_model_unit_tb: done, clean");
    end else begin
      $display("set_assoc_cache_tag_model_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("set_assoc_cache_tag_model_unit_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
